[rtl/core/fpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared constants and types for the fixed-point negative exponential pipeline.
// ----------------------------------------------------------------------------
package fpe_pkg;

   // Argument and result formats.
   localparam int FRACTION_BITS = 32;
   localparam int X_BITS        = 64;
   localparam int RESULT_BITS   = FRACTION_BITS + 1;

   // Series evaluation works at 30 fractional bits.
   localparam int TERM_FRAC_BITS  = 30;
   localparam int TERM_BITS       = TERM_FRAC_BITS + 1;
   localparam int SERIES_TERMS_DEF = 10;

   // ln 2 with 32 fractional bits.
   localparam logic [FRACTION_BITS-1:0] LN2_FIXED = 32'd2977044472;

   // The multiple of ln 2 is 0 .. FRACTION_BITS; anything at or above
   // K_LIMIT times ln 2 gives a zero result.
   localparam int K_LIMIT = FRACTION_BITS + 1;
   localparam int K_BITS  = 6;
   localparam logic [X_BITS-1:0] ZERO_LIMIT = X_BITS'(K_LIMIT) * X_BITS'(LN2_FIXED);

   // Arguments below ZERO_LIMIT fit in this many bits.
   localparam int REM_BITS = 37;

   // Reciprocal multiply for the truncating divide by a small constant.
   localparam int RECIP_SHIFT = TERM_FRAC_BITS + 4;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;

   // Bookkeeping that rides along with each item through the cells.
   typedef struct packed {
      logic              valid;
      logic              force_one;
      logic              force_zero;
      logic [K_BITS-1:0] k;
   } fpe_tag_type;

endpackage
`default_nettype wire

[rtl/core/fpe_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_div_cell
// One restoring-division step: tries ln 2 scaled by 2^STEP against the
// running remainder and sets the matching quotient bit.
// ----------------------------------------------------------------------------
module fpe_div_cell #(
   parameter int STEP = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire fpe_pkg::fpe_tag_type          tag_in,
   input  wire logic [fpe_pkg::REM_BITS-1:0]  rem_in,
   output fpe_pkg::fpe_tag_type               tag_out,
   output logic      [fpe_pkg::REM_BITS-1:0]  rem_out
);
   import fpe_pkg::*;

   localparam logic [REM_BITS-1:0] DIVISOR = REM_BITS'(LN2_FIXED) << STEP;

   fpe_tag_type         tag_ff, tag_in_c;
   logic [REM_BITS-1:0] rem_ff, rem_in_c;

   always_comb begin
      tag_in_c = tag_in;
      rem_in_c = rem_in;
      if (rem_in >= DIVISOR) begin
         rem_in_c        = rem_in - DIVISOR;
         tag_in_c.k[STEP] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_c;
      end
   end

   assign tag_out = tag_ff;
   assign rem_out = rem_ff;

endmodule
`default_nettype wire

[rtl/core/fpe_ser_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_ser_cell
// One level of the nested Taylor series: term_out = 1 - (r * term_in) / N,
// clamped at zero, over two register stages.
// ----------------------------------------------------------------------------
module fpe_ser_cell #(
   parameter int DIVISOR_N = 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                enable,
   input  wire fpe_pkg::fpe_tag_type                tag_in,
   input  wire logic [fpe_pkg::TERM_FRAC_BITS-1:0]  r_in,
   input  wire logic [fpe_pkg::TERM_BITS-1:0]       term_in,
   output fpe_pkg::fpe_tag_type                     tag_out,
   output logic      [fpe_pkg::TERM_FRAC_BITS-1:0]  r_out,
   output logic      [fpe_pkg::TERM_BITS-1:0]       term_out
);
   import fpe_pkg::*;

   localparam int PROD_BITS = TERM_FRAC_BITS + TERM_BITS;
   localparam int QUOT_BITS = TERM_FRAC_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR_N) - 64'd1) / 64'(DIVISOR_N));
   localparam logic [TERM_BITS-1:0] TERM_ONE = TERM_BITS'(1) << TERM_FRAC_BITS;

   fpe_tag_type               tag1_ff, tag2_ff;
   logic [TERM_FRAC_BITS-1:0] r1_ff, r2_ff;
   logic [PROD_BITS-1:0]      prod_ff, prod_in;
   logic [QUOT_BITS-1:0]      quot_ff, quot_in;
   logic [TERM_BITS-1:0]      quot_val;

   // r is below 2^30 and the term at most 2^30, so the product stays below 2^60.
   assign prod_in = PROD_BITS'(r_in) * PROD_BITS'(term_in);
   assign quot_in = QUOT_BITS'(prod_ff[2*TERM_FRAC_BITS-1:TERM_FRAC_BITS]) *
                    QUOT_BITS'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (enable) begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         r1_ff   <= r_in;
         quot_ff <= quot_in;
         r2_ff   <= r1_ff;
      end
   end

   assign quot_val = quot_ff[RECIP_SHIFT +: TERM_BITS];

   always_comb begin
      if (quot_val >= TERM_ONE) begin
         term_out = '0;
      end else begin
         term_out = TERM_ONE - quot_val;
      end
   end

   assign tag_out = tag2_ff;
   assign r_out   = r2_ff;

endmodule
`default_nettype wire

[rtl/core/fixed_point_exp_negative_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_exp_negative_top
// Pipelined exp(-x) for a signed argument with 32 fractional bits.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_stall  req_x_value    (64 bits, signed)
//  rsp_      out        rsp_valid / rsp_stall  rsp_exp_result (33 bits, unsigned)
//
// A new argument is taken in every cycle in which req_stall is low; each result
// is presented on rsp_ after passing the input register that loads at the
// transfer edge, the six division cells, the two stages of each series cell
// and the output register.
// Reset clears every valid flag in the chain; items in flight are dropped.
// A stalled result freezes the whole chain, and req_stall is raised for
// exactly the cycles in which the output register holds a stalled result.
// ----------------------------------------------------------------------------
module fixed_point_exp_negative_top #(
   parameter int SERIES_TERMS = fpe_pkg::SERIES_TERMS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [fpe_pkg::X_BITS-1:0]      req_x_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic             [fpe_pkg::RESULT_BITS-1:0] rsp_exp_result
);
   import fpe_pkg::*;

   localparam logic [TERM_BITS-1:0]   TERM_ONE   = TERM_BITS'(1) << TERM_FRAC_BITS;
   localparam logic [RESULT_BITS-1:0] RESULT_ONE = RESULT_BITS'(1) << FRACTION_BITS;

   // Valid flag of the output register, which holds a finished result.
   logic rsp_valid_ff;

   // The whole chain advances together unless a finished result is held.
   logic advance;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Input stage: classify the argument. Zero or negative gives exactly one,
   // and anything at or above 33 times ln 2 gives zero. Otherwise the
   // argument fits in REM_BITS and goes on to the division cells.
   fpe_tag_type         in_tag_ff, in_tag_in;
   logic [REM_BITS-1:0] in_rem_ff;

   always_comb begin
      in_tag_in            = '0;
      in_tag_in.valid      = req_valid;
      in_tag_in.force_one  = (req_x_value == '0) || req_x_value[X_BITS-1];
      in_tag_in.force_zero = !in_tag_in.force_one &&
                             (X_BITS'(req_x_value) >= ZERO_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff <= '0;
      end else if (advance) begin
         in_tag_ff <= in_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_rem_ff <= req_x_value[REM_BITS-1:0];
      end
   end

   // Division cells: one quotient bit each, most significant first. What is
   // left at the end is the remainder below ln 2.
   fpe_tag_type         div_tag [0:K_BITS];
   logic [REM_BITS-1:0] div_rem [0:K_BITS];

   assign div_tag[0] = in_tag_ff;
   assign div_rem[0] = in_rem_ff;

   for (genvar i = 0; i < K_BITS; i++) begin : g_div
      fpe_div_cell #(
         .STEP (K_BITS - 1 - i)
      ) u_div_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .tag_in  (div_tag[i]),
         .rem_in  (div_rem[i]),
         .tag_out (div_tag[i+1]),
         .rem_out (div_rem[i+1])
      );
   end

   // Series cells, innermost divisor first, down to a divisor of one, which
   // gives the outermost 1 - r * term step of the nested series.
   fpe_tag_type               ser_tag  [0:SERIES_TERMS];
   logic [TERM_FRAC_BITS-1:0] ser_r    [0:SERIES_TERMS];
   logic [TERM_BITS-1:0]      ser_term [0:SERIES_TERMS];

   assign ser_tag[0]  = div_tag[K_BITS];
   assign ser_r[0]    = div_rem[K_BITS][FRACTION_BITS-1:FRACTION_BITS-TERM_FRAC_BITS];
   assign ser_term[0] = TERM_ONE;

   for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_ser
      fpe_ser_cell #(
         .DIVISOR_N (SERIES_TERMS - i)
      ) u_ser_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .tag_in   (ser_tag[i]),
         .r_in     (ser_r[i]),
         .term_in  (ser_term[i]),
         .tag_out  (ser_tag[i+1]),
         .r_out    (ser_r[i+1]),
         .term_out (ser_term[i+1])
      );
   end

   // Output stage: back to 32 fractional bits, then scale by 2^-k, or give one or zero for a forced item.
   fpe_tag_type             last_tag;
   logic [RESULT_BITS-1:0]  scaled;
   logic [RESULT_BITS-1:0]  rsp_result_ff, rsp_result_in;

   assign last_tag = ser_tag[SERIES_TERMS];
   assign scaled   = {ser_term[SERIES_TERMS], (FRACTION_BITS - TERM_FRAC_BITS)'(0)};

   always_comb begin
      if (last_tag.force_one) begin
         rsp_result_in = RESULT_ONE;
      end else if (last_tag.force_zero) begin
         rsp_result_in = '0;
      end else begin
         rsp_result_in = scaled >> last_tag.k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_exp_result = rsp_result_ff;

   // The remainder left by the division cells is always below ln 2.
   a_rem_below_ln2: assert property (@(posedge clock) disable iff (reset)
      (div_tag[K_BITS].valid && !div_tag[K_BITS].force_one && !div_tag[K_BITS].force_zero)
      |-> (div_rem[K_BITS] < REM_BITS'(LN2_FIXED)))
      else $error("division remainder not below ln 2");

   // The multiple of ln 2 never exceeds the fraction width for a live item.
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (last_tag.valid && !last_tag.force_one && !last_tag.force_zero)
      |-> (last_tag.k < K_BITS'(K_LIMIT)))
      else $error("ln 2 multiple out of range");

   // No result is ever above one.
   a_result_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_exp_result <= RESULT_ONE))
      else $error("result above one");

   // A held result keeps the chain frozen, so the output stays valid next cycle.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("held result lost");

endmodule
`default_nettype wire
